// ----- rtl/ccpt_pkg.sv -----
// ----------------------------------------------------------------------------
// ccpt_pkg
// Shared types, constants and letter mapping for the cheat code patch table.
// ----------------------------------------------------------------------------
package ccpt_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int COUNT_W     = 7;

  localparam int IN_DATA_W   = 96;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 56;

  localparam logic [15:0] PATCH_BASE = 16'h8000;

  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_INVALID   = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  localparam int LEN_SHORT = 6;
  localparam int LEN_LONG  = 8;

  // One table entry: decoded patch plus the normalized letter nibbles.
  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  value;
    logic [7:0]  cmp;
    logic        has_cmp;
    logic [31:0] nib;      // nibble i at [4i+3:4i], upper two zero for short codes
    logic        long_code;
  } entry_t;

  // Code alphabet, position gives the nibble: A P Z L G I T Y E O X U K S V N
  localparam logic [7:0] ALPHABET [16] = '{
    8'h41, 8'h50, 8'h5A, 8'h4C, 8'h47, 8'h49, 8'h54, 8'h59,
    8'h45, 8'h4F, 8'h58, 8'h55, 8'h4B, 8'h53, 8'h56, 8'h4E
  };

  // Returns {ok, nibble}; lower case folds to upper case.
  function automatic logic [4:0] letter_nibble(input logic [7:0] raw);
    logic [7:0] c;
    logic [4:0] res;
    c   = raw;
    res = '0;
    if (c inside {[8'h61:8'h7A]}) begin
      c = c - 8'd32;
    end
    for (int i = 15; i >= 0; i--) begin
      if (ALPHABET[i] == c) begin
        res = {1'b1, 4'(i)};
      end
    end
    return res;
  endfunction

endpackage

// ----- rtl/ccpt_cell.sv -----
// ----------------------------------------------------------------------------
// ccpt_cell
// One table slot of the rotating entry ring.
// ----------------------------------------------------------------------------
module ccpt_cell
  import ccpt_pkg::*;
(
  input  logic   clk_i,
  input  logic   shift_i,      // take the neighbor's entry
  input  entry_t next_i,
  input  logic   load_i,       // direct write, used to fill a removal hole
  input  entry_t load_data_i,
  output entry_t entry_o
);

  entry_t entry_q;
  entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (shift_i) begin
      entry_d = next_i;
    end else if (load_i) begin
      entry_d = load_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- rtl/ccpt_decode.sv -----
// ----------------------------------------------------------------------------
// ccpt_decode
// Letter check and unscrambling of a 6 or 8 letter code into a patch entry.
// ----------------------------------------------------------------------------
module ccpt_decode
  import ccpt_pkg::*;
(
  input  logic [3:0]      code_length_i,
  input  logic [7:0][7:0] letters_i,
  output logic            valid_o,
  output entry_t          entry_o
);

  logic [7:0][4:0] lk;
  logic [7:0][3:0] n;
  logic            is_short;
  logic            is_long;
  logic            letters_ok;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lk[i] = letter_nibble(letters_i[i]);
    end
    is_short   = (code_length_i == 4'(LEN_SHORT));
    is_long    = (code_length_i == 4'(LEN_LONG));
    letters_ok = lk[0][4] & lk[1][4] & lk[2][4] & lk[3][4] & lk[4][4] & lk[5][4]
               & (!is_long | (lk[6][4] & lk[7][4]));
    valid_o    = (is_short | is_long) & letters_ok;

    for (int i = 0; i < 8; i++) begin
      n[i] = lk[i][3:0];
    end
    // short codes carry no seventh and eighth letter
    if (!is_long) begin
      n[6] = 4'd0;
      n[7] = 4'd0;
    end

    entry_o.addr      = PATCH_BASE | {1'b0, n[3][2:0], n[4][3], n[5][2:0],
                                      n[1][3], n[2][2:0], n[3][3], n[4][2:0]};
    entry_o.value     = {n[0][3], n[1][2:0], (is_long ? n[7][3] : n[5][3]), n[0][2:0]};
    entry_o.cmp       = is_long ? {n[6][3], n[7][2:0], n[5][3], n[6][2:0]} : 8'd0;
    entry_o.has_cmp   = is_long;
    entry_o.nib       = n;
    entry_o.long_code = is_long;
  end

endmodule

// ----- rtl/cheat_code_patch_table_top.sv -----
// ----------------------------------------------------------------------------
// cheat_code_patch_table_top
// Read-patch unit: code table with add, remove and patched ROM reads.
// ----------------------------------------------------------------------------
// The table lives in a ring of MAX_ENTRIES cells that rotates one slot per
// cycle during a scan past a single compare unit at the head. Every transfer
// (read, add or remove) takes one full turn of the ring and then a commit,
// which writes the result into the output register. The next input is taken
// in the cycle after the commit, once the result sits in the output register,
// so a new transfer is accepted only after the previous one has committed;
// a result that is still waiting on the output holds back the commit of the
// following item. Replacement and append are written into the ring as it
// turns; a removal refills its hole from the last entry in the commit cycle.
// Mode travels on s_axis_tuser; no clearing pass is needed after reset.
module cheat_code_patch_table_top
  import ccpt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [3:0] code_length, [67:4] letter_0..letter_7 (8 bits each, letter_0 lowest),
  // [83:68] access_addr, [91:84] base_data, [95:92] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] read_data, [8] patch_hit, [10:9] status, [26:11] decoded_addr,
  // [34:27] decoded_value, [42:35] decoded_compare, [49:43] entry_count, [55:50] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_ENTRIES - 1);

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       val_q, val_d;
  entry_t           held_q, held_d;

  logic [1:0]       q_mode_q;
  logic             q_valid_q;
  entry_t           q_entry_q;
  logic [15:0]      q_addr_q;
  logic [7:0]       q_base_q;

  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  logic   dec_valid;
  entry_t dec_entry;

  entry_t cell_q [MAX_ENTRIES];
  entry_t head;
  entry_t tail_in;
  logic   accept;
  logic   scanning;
  logic   commit;
  logic   in_range;
  logic   match;
  logic   hit_now;
  logic   repl;
  logic   do_fill;
  logic   table_full;

  ccpt_decode u_decode (
    .code_length_i (s_axis_tdata[3:0]),
    .letters_i     (s_axis_tdata[67:4]),
    .valid_o       (dec_valid),
    .entry_o       (dec_entry)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign scanning      = (state_q == S_SCAN);
  assign commit        = (state_q == S_DONE) & (!m_valid_q | m_axis_tready);
  assign head          = cell_q[0];
  assign table_full    = (cnt_q == CNT_W'(MAX_ENTRIES));

  // head compare, one original table index per scan step
  always_comb begin
    in_range = ({{(CNT_W-IDX_W){1'b0}}, step_q} < cnt_q);
    case (q_mode_q)
      MODE_READ:   match = q_addr_q[15] & (head.addr == q_addr_q)
                           & (!head.has_cmp | (head.cmp == q_base_q));
      MODE_ADD:    match = q_valid_q & (head.addr == q_entry_q.addr);
      MODE_REMOVE: match = q_valid_q & (head.long_code == q_entry_q.long_code)
                           & (head.nib == q_entry_q.nib);
      default:     match = 1'b0;
    endcase
    hit_now = scanning & in_range & !found_q & match;
    // add: overwrite the matching slot, or append at the first free slot
    repl = scanning & (q_mode_q == MODE_ADD) & q_valid_q
         & (hit_now | (!found_q & ({{(CNT_W-IDX_W){1'b0}}, step_q} == cnt_q)));
    tail_in = repl ? q_entry_q : head;
    do_fill = commit & (q_mode_q == MODE_REMOVE) & q_valid_q & found_q;
  end

  for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
    entry_t nxt;
    if (gi == MAX_ENTRIES - 1) begin : g_tail
      assign nxt = tail_in;
    end else begin : g_mid
      assign nxt = cell_q[gi+1];
    end
    ccpt_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (scanning),
      .next_i      (nxt),
      .load_i      (do_fill & (idx_q == IDX_W'(gi))),
      .load_data_i (held_q),
      .entry_o     (cell_q[gi])
    );
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    found_d   = found_q;
    idx_d     = idx_q;
    val_d     = val_q;
    held_d    = held_q;
    m_valid_d = m_valid_q & !m_axis_tready;
    m_data_d  = m_data_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          step_d  = '0;
          found_d = 1'b0;
        end
      end
      S_SCAN: begin
        if (hit_now) begin
          found_d = 1'b1;
          idx_d   = step_q;
          val_d   = head.value;
        end
        // keep the last active entry to refill a removal hole
        if ((cnt_q != '0) && ({{(CNT_W-IDX_W){1'b0}}, step_q} == cnt_q - 1'b1)) begin
          held_d = head;
        end
        if (step_q == LAST_STEP) begin
          state_d = S_DONE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DONE: begin
        if (commit) begin
          logic [7:0]  rd;
          logic        hit;
          logic [1:0]  stat;
          logic        show;
          rd   = 8'd0;
          hit  = 1'b0;
          stat = STAT_OK;
          show = 1'b0;
          case (q_mode_q)
            MODE_READ: begin
              hit = found_q;
              rd  = found_q ? val_q : q_base_q;
            end
            MODE_ADD: begin
              if (!q_valid_q) begin
                stat = STAT_INVALID;
              end else begin
                show = 1'b1;
                if (!found_q) begin
                  if (table_full) begin
                    stat = STAT_FULL;
                  end else begin
                    cnt_d = cnt_q + 1'b1;
                  end
                end
              end
            end
            MODE_REMOVE: begin
              if (!q_valid_q) begin
                stat = STAT_INVALID;
              end else if (!found_q) begin
                stat = STAT_NOT_FOUND;
              end else begin
                cnt_d = cnt_q - 1'b1;
              end
            end
            default: stat = STAT_INVALID;
          endcase
          m_data_d = {6'd0, COUNT_W'(cnt_d),
                      show ? q_entry_q.cmp : 8'd0,
                      show ? q_entry_q.value : 8'd0,
                      show ? q_entry_q.addr : 16'd0,
                      stat, hit, rd};
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      cnt_q     <= cnt_d;
      found_q   <= found_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    val_q    <= val_d;
    held_q   <= held_d;
    m_data_q <= m_data_d;
    if (accept) begin
      q_mode_q  <= s_axis_tuser[1:0];
      q_valid_q <= dec_valid;
      q_entry_q <= dec_entry;
      q_addr_q  <= s_axis_tdata[83:68];
      q_base_q  <= s_axis_tdata[91:84];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_count_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(cnt_q))
    else $error("entry count changed outside commit");

  a_result_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised without a commit");

  a_scan_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scanning && step_q != LAST_STEP) |=> (scanning && step_q == $past(step_q) + 1'b1))
    else $error("ring scan did not advance");

endmodule
